// File: design/car_pkg.sv
package car_pkg;

  localparam int COMB_DEPTH    = 4096;
  localparam int ALLPASS_DEPTH = 512;
  localparam int NUM_COMB      = 3;

  localparam int CA_W = $clog2(COMB_DEPTH);
  localparam int AA_W = $clog2(ALLPASS_DEPTH);
  localparam int CL_W = CA_W + 1;
  localparam int AL_W = AA_W + 1;

  localparam int CLR_DEPTH = (COMB_DEPTH > ALLPASS_DEPTH) ? COMB_DEPTH : ALLPASS_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam int CLEN_W  = 13;
  localparam int ALEN_W  = 10;
  localparam int PADDR_W = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int OUT_DEPTH   = 8;
  localparam int O_AW        = $clog2(OUT_DEPTH);

  localparam logic [1:0] COMB_SHIFT [NUM_COMB] = '{2'd2, 2'd3, 2'd3};
  localparam logic [1:0] AP_SHIFT = 2'd2;

  localparam logic [1:0]        RST_DEPTH_SHIFT  = 2'd1;
  localparam logic [CLEN_W-1:0] RST_COMB1_LENGTH = 13'd1124;
  localparam logic [CLEN_W-1:0] RST_COMB2_LENGTH = 13'd595;
  localparam logic [CLEN_W-1:0] RST_COMB3_LENGTH = 13'd948;
  localparam logic [ALEN_W-1:0] RST_AP_LENGTH    = 10'd154;

  typedef enum logic [2:0] {
    REG_STEREO_MODE    = 3'd0,
    REG_DEPTH_SHIFT    = 3'd1,
    REG_COMB1_LENGTH   = 3'd2,
    REG_COMB2_LENGTH   = 3'd3,
    REG_COMB3_LENGTH   = 3'd4,
    REG_ALLPASS_LENGTH = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                             stereo_mode;
    logic [1:0]                       depth_shift;
    logic [NUM_COMB-1:0][CLEN_W-1:0] comb_len;
    logic [ALEN_W-1:0]                allpass_len;
  } cfg_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } result_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [1:0] s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [CL_W-1:0] comb_eff_len(input logic [CLEN_W-1:0] len);
    if (len < CLEN_W'(2)) return CL_W'(2);
    if (int'(len) > COMB_DEPTH) return CL_W'(COMB_DEPTH);
    return CL_W'(len);
  endfunction

  function automatic logic [AL_W-1:0] ap_eff_len(input logic [ALEN_W-1:0] len);
    if (len < ALEN_W'(2)) return AL_W'(2);
    if (int'(len) > ALLPASS_DEPTH) return AL_W'(ALLPASS_DEPTH);
    return AL_W'(len);
  endfunction

  function automatic logic [CA_W-1:0] comb_next(input logic [CA_W-1:0] pos,
                                                input logic [CL_W-1:0] len);
    logic [CL_W-1:0] n;
    n = {1'b0, pos} + CL_W'(1);
    return (n >= len) ? '0 : n[CA_W-1:0];
  endfunction

  function automatic logic [CA_W-1:0] comb_wr(input logic [CA_W-1:0] pos,
                                              input logic [CL_W-1:0] len);
    logic [CL_W-1:0] lm1;
    lm1 = len - CL_W'(1);
    return ({1'b0, pos} >= len) ? lm1[CA_W-1:0] : pos;
  endfunction

  function automatic logic [AA_W-1:0] ap_next(input logic [AA_W-1:0] pos,
                                              input logic [AL_W-1:0] len);
    logic [AL_W-1:0] n;
    n = {1'b0, pos} + AL_W'(1);
    return (n >= len) ? '0 : n[AA_W-1:0];
  endfunction

  function automatic logic [AA_W-1:0] ap_wr(input logic [AA_W-1:0] pos,
                                            input logic [AL_W-1:0] len);
    logic [AL_W-1:0] lm1;
    lm1 = len - AL_W'(1);
    return ({1'b0, pos} >= len) ? lm1[AA_W-1:0] : pos;
  endfunction

endpackage

// File: design/comb_allpass_reverb.sv
// Three-comb, one all-pass reverb on stereo mix frames.
// Input channel in_valid/in_ready carries one frame (left, right, last marker);
// output channel out_valid/out_ready returns exactly one frame per input, in order.
// Mono mode feeds the left sample into the reverb and leaves right untouched;
// stereo mode feeds (L+R)>>1, adds the wet signal to left and subtracts it from right.
// Registers sit on an APB-style port at byte addresses 4*i, pready tied high;
// write them only while no frame is in flight.
// Path: a frame accepted on in_* passes the input register, the queue, engine stages
// s1, s2 and s3 and the output buffer before it shows on out_*. Throughput: one frame
// per cycle while the output buffer has room, set by the single read and write port of
// each delay memory, with the write of one frame overlapping the read of the next.
// Reset: rst_n is synchronous. The registers take their default values and all four
// delay memories are zeroed in a clearing pass over every address, during which in_ready
// stays low; configuration writes are taken throughout.
// Stall: results queue in an 8-entry output buffer; a four-entry queue between the
// input stage and the delay-line engine lets input keep flowing until both fill.
module comb_allpass_reverb (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_left_in,
  input  logic signed [31:0]           in_right_in,
  input  logic                         in_frame_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_left_out,
  output logic signed [31:0]           out_right_out,
  output logic                         out_frame_last_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [car_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  car_pkg::cfg_t    cfg_r;
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic             push_valid, push_ready;
  car_pkg::item_t   push_item;
  logic             q_valid, q_pop, clr_busy;
  car_pkg::item_t   q_item;
  car_pkg::result_t res;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stereo_mode <= 1'b0;
      cfg_r.depth_shift <= car_pkg::RST_DEPTH_SHIFT;
      cfg_r.comb_len[0] <= car_pkg::RST_COMB1_LENGTH;
      cfg_r.comb_len[1] <= car_pkg::RST_COMB2_LENGTH;
      cfg_r.comb_len[2] <= car_pkg::RST_COMB3_LENGTH;
      cfg_r.allpass_len <= car_pkg::RST_AP_LENGTH;
    end else if (wr_en) begin
      case (reg_idx)
        car_pkg::REG_STEREO_MODE:    cfg_r.stereo_mode <= pwdata[0];
        car_pkg::REG_DEPTH_SHIFT:    cfg_r.depth_shift <= pwdata[1:0];
        car_pkg::REG_COMB1_LENGTH:   cfg_r.comb_len[0] <= pwdata[car_pkg::CLEN_W-1:0];
        car_pkg::REG_COMB2_LENGTH:   cfg_r.comb_len[1] <= pwdata[car_pkg::CLEN_W-1:0];
        car_pkg::REG_COMB3_LENGTH:   cfg_r.comb_len[2] <= pwdata[car_pkg::CLEN_W-1:0];
        car_pkg::REG_ALLPASS_LENGTH: cfg_r.allpass_len <= pwdata[car_pkg::ALEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      car_pkg::REG_STEREO_MODE:    prdata = 32'(cfg_r.stereo_mode);
      car_pkg::REG_DEPTH_SHIFT:    prdata = 32'(cfg_r.depth_shift);
      car_pkg::REG_COMB1_LENGTH:   prdata = 32'(cfg_r.comb_len[0]);
      car_pkg::REG_COMB2_LENGTH:   prdata = 32'(cfg_r.comb_len[1]);
      car_pkg::REG_COMB3_LENGTH:   prdata = 32'(cfg_r.comb_len[2]);
      car_pkg::REG_ALLPASS_LENGTH: prdata = 32'(cfg_r.allpass_len);
      default:                     prdata = 32'd0;
    endcase
  end

  car_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .stereo_mode   (cfg_r.stereo_mode),
    .clr_busy      (clr_busy),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .in_frame_last (in_frame_last),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  car_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .head_item  (q_item)
  );

  car_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_left_out       = res.left;
  assign out_right_out      = res.right;
  assign out_frame_last_out = res.last;

endmodule

// File: design/car_front.sv
module car_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            stereo_mode,
  input  logic            clr_busy,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [31:0]     in_left_in,
  input  logic [31:0]     in_right_in,
  input  logic            in_frame_last,
  output logic            push_valid,
  input  logic            push_ready,
  output car_pkg::item_t  push_item
);

  logic           fv_r;
  logic           fv_nxt;
  car_pkg::item_t item_r;
  car_pkg::item_t item_nxt;
  logic           take;

  assign in_ready   = !clr_busy && (!fv_r || push_ready);
  assign take       = in_valid && in_ready;
  assign push_valid = fv_r;
  assign push_item  = item_r;

  always_comb begin
    item_nxt.left  = in_left_in;
    item_nxt.right = in_right_in;
    item_nxt.last  = in_frame_last;
    item_nxt.x     = stereo_mode ? car_pkg::asr32(in_left_in + in_right_in, 2'd1)
                                 : in_left_in;
    fv_nxt = take || (fv_r && !push_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: design/car_queue.sv
module car_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  car_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop,
  output car_pkg::item_t  head_item
);

  car_pkg::item_t               slot_r [car_pkg::QUEUE_DEPTH];
  logic [car_pkg::Q_AW-1:0]     wp_r;
  logic [car_pkg::Q_AW-1:0]     rp_r;
  logic [car_pkg::Q_AW:0]       cnt_r;
  logic                         do_push;

  assign push_ready = cnt_r < (car_pkg::Q_AW + 1)'(car_pkg::QUEUE_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign head_item  = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (pop)     rp_r <= rp_r + 1'b1;
      if (do_push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// File: design/car_back.sv
module car_back (
  input  logic              clk,
  input  logic              rst_n,
  input  car_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  car_pkg::item_t    q_item,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              res_valid,
  input  logic              res_ready,
  output car_pkg::result_t  res
);

  localparam int NC   = car_pkg::NUM_COMB;
  localparam int CA_W = car_pkg::CA_W;
  localparam int AA_W = car_pkg::AA_W;
  localparam int OC_W = car_pkg::O_AW + 2;

  // clearing pass
  logic                      clr_r;
  logic [car_pkg::CLR_W-1:0] clr_addr_r;

  // stage valids and payload
  logic                      v1_r, v2_r, v3_r;
  car_pkg::item_t            s1_r;
  logic [CA_W-1:0]           s1_p_r [NC];
  logic [31:0]               s2_sum_r, s2_left_r, s2_right_r;
  logic                      s2_last_r;
  logic [AA_W-1:0]           s2_p_r;
  logic [31:0]               s3_dap_r, s3_stored_r, s3_left_r, s3_right_r;
  logic                      s3_last_r;

  // comb lanes
  logic [CA_W-1:0]           cpos_r [NC];
  logic [CA_W-1:0]           c_rd [NC];
  logic [CA_W-1:0]           c_wp [NC];
  logic [31:0]               c_d [NC];
  logic [31:0]               c_wval [NC];
  logic [31:0]               c_sum;

  // all-pass
  logic [AA_W-1:0]           apos_r;
  logic [car_pkg::AL_W-1:0]  ap_len;
  logic [AA_W-1:0]           ap_rd, ap_wp;
  logic [31:0]               ap_rdata_r, ap_bypd_r;
  logic                      ap_byp_r;
  logic [31:0]               ap_d, ap_stored;
  logic [31:0]               ap_mem [car_pkg::ALLPASS_DEPTH];

  // output buffer
  car_pkg::result_t          obuf_r [car_pkg::OUT_DEPTH];
  logic [car_pkg::O_AW-1:0]  owp_r, orp_r;
  logic [car_pkg::O_AW:0]    ocnt_r;
  logic [OC_W-1:0]           occ;
  logic                      issue, opop;
  logic [31:0]               wet, wet_sh;
  car_pkg::result_t          res_nxt;

  assign clr_busy = clr_r;
  assign occ = OC_W'(ocnt_r) + OC_W'(v1_r) + OC_W'(v2_r) + OC_W'(v3_r);
  assign issue = q_valid && !clr_r && (occ < OC_W'(car_pkg::OUT_DEPTH));
  assign q_pop = issue;

  for (genvar g = 0; g < NC; g++) begin : g_comb
    logic [31:0]              mem [car_pkg::COMB_DEPTH];
    logic [car_pkg::CL_W-1:0] len;
    logic [31:0]              rdata_r, bypd_r;
    logic                     byp_r;
    logic                     we;
    logic [CA_W-1:0]          wa;
    logic [31:0]              wd;

    assign len       = car_pkg::comb_eff_len(cfg.comb_len[g]);
    assign c_rd[g]   = car_pkg::comb_next(cpos_r[g], len);
    assign c_wp[g]   = car_pkg::comb_wr(cpos_r[g], len);
    assign c_d[g]    = byp_r ? bypd_r : rdata_r;
    assign c_wval[g] = s1_r.x + c_d[g] - car_pkg::asr32(c_d[g], car_pkg::COMB_SHIFT[g]);
    assign we        = clr_r || v1_r;
    assign wa        = clr_r ? clr_addr_r[CA_W-1:0] : s1_p_r[g];
    assign wd        = clr_r ? 32'd0 : c_wval[g];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
      rdata_r <= mem[c_rd[g]];
      byp_r   <= v1_r && (s1_p_r[g] == c_rd[g]);
      bypd_r  <= c_wval[g];
      if (issue) begin
        s1_p_r[g] <= c_wp[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cpos_r[g] <= '0;
      end else if (issue) begin
        cpos_r[g] <= c_rd[g];
      end
    end
  end

  always_comb begin
    c_sum = '0;
    for (int i = 0; i < NC; i++) begin
      c_sum = c_sum + c_d[i];
    end
  end

  assign ap_len    = car_pkg::ap_eff_len(cfg.allpass_len);
  assign ap_rd     = car_pkg::ap_next(apos_r, ap_len);
  assign ap_wp     = car_pkg::ap_wr(apos_r, ap_len);
  assign ap_d      = ap_byp_r ? ap_bypd_r : ap_rdata_r;
  assign ap_stored = s2_sum_r + ap_d - car_pkg::asr32(ap_d, car_pkg::AP_SHIFT);

  always_ff @(posedge clk) begin
    if (clr_r) begin
      ap_mem[clr_addr_r[AA_W-1:0]] <= 32'd0;
    end else if (v2_r) begin
      ap_mem[s2_p_r] <= ap_stored;
    end
    ap_rdata_r <= ap_mem[ap_rd];
    ap_byp_r   <= v2_r && (s2_p_r == ap_rd);
    ap_bypd_r  <= ap_stored;
  end

  always_comb begin
    wet           = s3_dap_r - s3_stored_r + car_pkg::asr32(s3_stored_r, car_pkg::AP_SHIFT);
    wet_sh        = car_pkg::asr32(wet, cfg.depth_shift);
    res_nxt.left  = s3_left_r + wet_sh;
    res_nxt.right = cfg.stereo_mode ? (s3_right_r - wet_sh) : s3_right_r;
    res_nxt.last  = s3_last_r;
  end

  assign res_valid = ocnt_r != '0;
  assign res       = obuf_r[orp_r];
  assign opop      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      apos_r     <= '0;
      owp_r      <= '0;
      orp_r      <= '0;
      ocnt_r     <= '0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == car_pkg::CLR_W'(car_pkg::CLR_DEPTH - 1)) clr_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v1_r) apos_r <= ap_rd;
      if (v3_r) owp_r <= owp_r + 1'b1;
      if (opop) orp_r <= orp_r + 1'b1;
      if (v3_r && !opop)      ocnt_r <= ocnt_r + 1'b1;
      else if (!v3_r && opop) ocnt_r <= ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_r <= q_item;
    end
    if (v1_r) begin
      s2_sum_r   <= c_sum;
      s2_left_r  <= s1_r.left;
      s2_right_r <= s1_r.right;
      s2_last_r  <= s1_r.last;
      s2_p_r     <= ap_wp;
    end
    if (v2_r) begin
      s3_dap_r    <= ap_d;
      s3_stored_r <= ap_stored;
      s3_left_r   <= s2_left_r;
      s3_right_r  <= s2_right_r;
      s3_last_r   <= s2_last_r;
    end
    if (v3_r) begin
      obuf_r[owp_r] <= res_nxt;
    end
  end

endmodule

// File: design/car_check.sv
module car_check (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [31:0]           out_left_out,
  input logic signed [31:0]           out_right_out,
  input logic                         out_frame_last_out,
  input logic                         psel,
  input logic                         pwrite,
  input logic [car_pkg::PADDR_W-1:0]  paddr,
  input logic [31:0]                  prdata
);

  logic [5:0] pend_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 6'(in_xfer) - 6'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out)
      && $stable(out_right_out) && $stable(out_frame_last_out))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channels not idle after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> (pend_r != 6'd0) || in_xfer)
    else $error("result transfer without a pending frame");

  a_mode_width: assert property (@(posedge clk) disable iff (!rst_n)
    psel && !pwrite && (paddr == car_pkg::PADDR_W'(0)) |-> prdata[31:1] == 31'd0)
    else $error("stereo mode readback wider than one bit");

endmodule

bind comb_allpass_reverb car_check u_car_check (.*);
